/* src/ppdm_pkg.sv */
// Shared types and constants of the PWM period and duty meter.
package ppdm_pkg;

   // Field widths.
   localparam int CNT_W  = 16;   // capture counter width
   localparam int PER_W  = CNT_W + 1;
   localparam int TICK_W = 27;
   localparam int DUTY_W = 7;

   // Tick rate after reset and the duty ceiling.
   localparam logic [TICK_W-1:0] TICK_RATE_RESET = TICK_W'(1000000);
   localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(100);

   // Divider step count: one quotient bit per cycle over the widest dividend.
   localparam int DIV_STEPS = TICK_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Meter sequencer states.
   typedef enum logic [2:0] {
      ST_WAIT_RISE,
      ST_WAIT_FALL,
      ST_WAIT_RISE2,
      ST_FREQ_START,
      ST_FREQ_WAIT,
      ST_DUTY_START,
      ST_DUTY_WAIT,
      ST_DONE
   } ppdm_state_type;

   // Divider status toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } ppdm_div_stat_type;

endpackage

/* src/pwm_period_duty_meter_unit.sv */
// Top level of the PWM period, frequency and duty meter.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_edge_rising, req_stamp
//   rsp      out        rsp_valid/rsp_stall  rsp_period_ticks, rsp_frequency, rsp_duty_percent
//   csr      in         csr_wr_en            csr_wr_data (tick rate)
//
// Capture requests that do not close a measurement are taken without a stall.
// The second rising edge starts two passes of the bit-serial divider, 27 shift
// steps each, first frequency and then duty; the result register is loaded
// once both passes are done and the output register is free.
// Reset is synchronous and returns to waiting for a first rising edge.
// req_stall is high from the closing request until its result is loaded, and
// longer while an earlier result still waits unaccepted in the output register.
module pwm_period_duty_meter_unit
   import ppdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_edge_rising,
   input  logic [CNT_W-1:0]  req_stamp,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PER_W-1:0]  rsp_period_ticks,
   output logic [TICK_W-1:0] rsp_frequency,
   output logic [DUTY_W-1:0] rsp_duty_percent,
   input  logic              csr_wr_en,
   input  logic [TICK_W-1:0] csr_wr_data
);

   ppdm_state_type    state_ff, state_in;
   logic [TICK_W-1:0] tick_rate_ff;
   logic [CNT_W-1:0]  rise_ff, fall_ff;
   logic [PER_W-1:0]  period_ff;
   logic [CNT_W-1:0]  high_ff;
   logic [TICK_W-1:0] freq_ff;
   logic [DUTY_W-1:0] duty_ff;
   logic              rsp_valid_ff;
   logic [PER_W-1:0]  rsp_period_ff;
   logic [TICK_W-1:0] rsp_freq_ff;
   logic [DUTY_W-1:0] rsp_duty_ff;

   logic              req_take;
   logic              out_free;
   logic              load_rsp;
   logic              div_start;
   logic              div_sel_duty;
   logic [TICK_W-1:0] div_dividend;
   logic [TICK_W-1:0] div_quotient;
   ppdm_div_stat_type div_stat;
   logic [CNT_W-1:0]  period_diff;
   logic [PER_W-1:0]  period_in;
   logic [TICK_W-1:0] high_x100;

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Period and high time modulo the counter wrap; equal stamps mean a full wrap.
   always_comb begin
      period_diff = req_stamp - rise_ff;
      period_in   = (period_diff == '0) ? {1'b1, {CNT_W{1'b0}}} : {1'b0, period_diff};
   end

   // High time times 100 as shifts and adds: 64 + 32 + 4.
   always_comb begin
      high_x100 = (TICK_W'(high_ff) << 6) + (TICK_W'(high_ff) << 5)
                + (TICK_W'(high_ff) << 2);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_WAIT_RISE: begin
            if (req_take && req_edge_rising) state_in = ST_WAIT_FALL;
         end
         ST_WAIT_FALL: begin
            if (req_take && !req_edge_rising) state_in = ST_WAIT_RISE2;
         end
         ST_WAIT_RISE2: begin
            if (req_take && req_edge_rising) state_in = ST_FREQ_START;
         end
         ST_FREQ_START: state_in = ST_FREQ_WAIT;
         ST_FREQ_WAIT: begin
            if (div_stat.done) state_in = ST_DUTY_START;
         end
         ST_DUTY_START: state_in = ST_DUTY_WAIT;
         ST_DUTY_WAIT: begin
            if (div_stat.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_WAIT_RISE;
         end
         default: state_in = ST_WAIT_RISE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall    = 1'b1;
      div_start    = 1'b0;
      div_sel_duty = 1'b0;
      load_rsp     = 1'b0;
      unique case (state_ff)
         ST_WAIT_RISE, ST_WAIT_FALL, ST_WAIT_RISE2: req_stall = 1'b0;
         ST_FREQ_START: div_start = 1'b1;
         ST_DUTY_START: begin
            div_start    = 1'b1;
            div_sel_duty = 1'b1;
         end
         ST_DONE: load_rsp = out_free;
         default: req_stall = 1'b1;
      endcase
   end

   assign div_dividend = div_sel_duty ? high_x100 : tick_rate_ff;

   ppdm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (period_ff),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   // Control registers: state, tick rate and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT_RISE;
         tick_rate_ff <= TICK_RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            tick_rate_ff <= csr_wr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Captured stamps and measurement results.
   always_ff @(posedge clock) begin
      if (req_take && req_edge_rising && state_ff == ST_WAIT_RISE) begin
         rise_ff <= req_stamp;
      end
      if (req_take && !req_edge_rising && state_ff == ST_WAIT_FALL) begin
         fall_ff <= req_stamp;
      end
      if (req_take && req_edge_rising && state_ff == ST_WAIT_RISE2) begin
         period_ff <= period_in;
         high_ff   <= fall_ff - rise_ff;
      end
      if (state_ff == ST_FREQ_WAIT && div_stat.done) begin
         freq_ff <= div_quotient;
      end
      if (state_ff == ST_DUTY_WAIT && div_stat.done) begin
         duty_ff <= (div_quotient > TICK_W'(DUTY_MAX)) ? DUTY_MAX
                                                        : div_quotient[DUTY_W-1:0];
      end
      if (load_rsp) begin
         rsp_period_ff <= period_ff;
         rsp_freq_ff   <= freq_ff;
         rsp_duty_ff   <= duty_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_period_ticks = rsp_period_ff;
   assign rsp_frequency    = rsp_freq_ff;
   assign rsp_duty_percent = rsp_duty_ff;

endmodule

/* src/ppdm_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module ppdm_divider
   import ppdm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [TICK_W-1:0]       dividend,
   input  logic [PER_W-1:0]        divisor,
   output ppdm_div_stat_type       stat,
   output logic [TICK_W-1:0]       quotient
);

   logic [PER_W-1:0]  rem_ff, rem_in;
   logic [TICK_W-1:0] quo_ff, quo_in;
   logic [PER_W-1:0]  div_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PER_W:0]    rem_shift;
   logic              fits;

   // One restoring step: bring down the next dividend bit, subtract if it fits.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[TICK_W-1]};
      fits      = rem_shift >= {1'b0, div_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? PER_W'(rem_shift - {1'b0, div_ff}) : rem_shift[PER_W-1:0];
         quo_in = {quo_ff[TICK_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath shift registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
